FILE: design/tfsag_pkg.sv
`timescale 1ns / 1ps

package tfsag_pkg;

    localparam int ANGLE_W         = 20;
    localparam int RANGE_W         = 19;
    localparam int CURV_W          = 20;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int SQ_W            = 2 * RANGE_W;
    localparam int PROD_W          = CURV_W + SQ_W;
    localparam int RND_W           = PROD_W - 2 * ANGLE_FRAC_BITS + 1;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 20;

    localparam logic [ANGLE_W-1:0] TILT_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        FACE_NADIR    = 2'd0,
        FACE_FORWARD  = 2'd1,
        FACE_BACKWARD = 2'd2
    } t_face;

    typedef struct packed {
        logic [RANGE_W-1:0]        scan_half_range;
        logic [RANGE_W-1:0]        pulse_step;
        logic [CURV_W-1:0]         curvature;
        logic [RANGE_W-1:0]        centre_tilt;
        logic [RANGE_W-1:0]        nadir_limit;
        logic [RANGE_W-1:0]        tilted_limit;
        logic signed [ANGLE_W-1:0] vertical_min;
        logic signed [ANGLE_W-1:0] vertical_max;
    } t_cfg;

    // one classified pulse on its way to the tilt pipeline
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        t_face                     face;
        logic                      left;
        logic [RANGE_W-1:0]        mag;
    } t_job;

endpackage

FILE: design/tfsag_queue.sv
`timescale 1ns / 1ps

module tfsag_queue
    import tfsag_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) ||
                 (r_count == $past(r_count) + CNT_W'(1)) ||
                 (r_count + CNT_W'(1) == $past(r_count)))
        else $error("queue count jumped");

endmodule

FILE: design/tfsag_front.sv
`timescale 1ns / 1ps

module tfsag_front
    import tfsag_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_push,
    input  logic i_restart,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);

    logic [ANGLE_W-1:0] r_angle;
    t_face              r_face;

    logic [ANGLE_W-1:0] n_base;
    t_face              n_base_face;
    t_face              n_step_face;
    logic [ANGLE_W:0]   n_sum;
    logic               n_wrap;
    logic [ANGLE_W-1:0] n_angle;
    t_face              n_face;
    logic [ANGLE_W-1:0] n_mag;
    logic [RANGE_W-1:0] n_limit;
    logic               n_left;
    logic [RANGE_W-1:0] n_clamp;

    assign o_push = i_push && !i_full;

    always_comb begin
        n_base      = i_restart ? '0 : r_angle;
        n_base_face = i_restart ? FACE_NADIR : r_face;
        case (n_base_face)
            FACE_NADIR:   n_step_face = FACE_FORWARD;
            FACE_FORWARD: n_step_face = FACE_BACKWARD;
            default:      n_step_face = FACE_NADIR;
        endcase
        n_sum   = {n_base[ANGLE_W-1], n_base} + {2'b00, i_cfg.pulse_step};
        n_wrap  = $signed(n_sum) > $signed({2'b00, i_cfg.scan_half_range});
        n_angle = n_wrap ? (ANGLE_W'(0) - {1'b0, i_cfg.scan_half_range})
                         : n_sum[ANGLE_W-1:0];
        n_face  = n_wrap ? n_step_face : n_base_face;
        n_mag   = n_angle[ANGLE_W-1] ? (ANGLE_W'(0) - n_angle) : n_angle;
        n_limit = (n_face == FACE_NADIR) ? i_cfg.nadir_limit : i_cfg.tilted_limit;
        n_left  = (n_mag <= {1'b0, n_limit})
               && ($signed(n_angle) >= $signed(i_cfg.vertical_min))
               && ($signed(n_angle) <= $signed(i_cfg.vertical_max));
        // tilt sees the magnitude clamped to the sweep
        n_clamp = (n_mag > {1'b0, i_cfg.scan_half_range}) ? i_cfg.scan_half_range
                                                         : n_mag[RANGE_W-1:0];
        o_job.angle = n_angle;
        o_job.face  = n_face;
        o_job.left  = n_left;
        o_job.mag   = n_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_face  <= FACE_NADIR;
        end else if (o_push) begin
            r_angle <= n_angle;
            r_face  <= n_face;
        end
    end

    a_wrap_to_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && n_wrap |=> r_angle == ANGLE_W'(0) - {1'b0, i_cfg.scan_half_range})
        else $error("wrap did not land on the negative half range");

endmodule

FILE: design/tfsag_back.sv
`timescale 1ns / 1ps

module tfsag_back
    import tfsag_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_job                i_job,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [ANGLE_W-1:0]  o_beam_angle,
    output logic [ANGLE_W-1:0]  o_forward_angle,
    output logic [1:0]          o_face,
    output logic                o_pulse_left
);

    localparam int LO_W  = RANGE_W;
    localparam int HI_W  = SQ_W - LO_W;
    localparam int SUM_W = ((RND_W > RANGE_W) ? RND_W : RANGE_W) + 1;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (2 * ANGLE_FRAC_BITS - 1);

    logic                     w_en;

    logic                     r_a_valid;
    t_job                     r_a_job;
    logic [SQ_W-1:0]          r_a_sq;
    logic                     r_b_valid;
    t_job                     r_b_job;
    logic [CURV_W+LO_W-1:0]   r_b_lo;
    logic [CURV_W+HI_W-1:0]   r_b_hi;
    logic                     r_c_valid;
    t_job                     r_c_job;
    logic [RND_W-1:0]         r_c_rnd;
    logic                     r_out_valid;
    t_job                     r_out_job;
    logic [ANGLE_W-1:0]       r_out_fwd;

    logic [PROD_W:0]          n_prod;
    logic [SUM_W-1:0]         n_sum;
    logic [ANGLE_W-1:0]       n_tilt;
    logic [ANGLE_W-1:0]       n_fwd;

    // the whole pipeline moves together while the result slot is free or its result is popped
    assign w_en    = !r_out_valid || i_pop;
    assign o_q_pop = w_en && !i_q_empty;

    always_comb begin
        n_prod = {1'b0, r_b_hi, {LO_W{1'b0}}} + (PROD_W + 1)'(r_b_lo) + HALF;
        n_sum  = SUM_W'(r_c_rnd) + SUM_W'(i_cfg.centre_tilt);
        n_tilt = (n_sum > SUM_W'(TILT_MAX)) ? TILT_MAX : n_sum[ANGLE_W-1:0];
        case (r_c_job.face)
            FACE_FORWARD:  n_fwd = n_tilt;
            FACE_BACKWARD: n_fwd = ANGLE_W'(0) - n_tilt;
            default:       n_fwd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_job   <= i_job;
            r_a_sq    <= SQ_W'(i_job.mag) * SQ_W'(i_job.mag);
            r_b_job   <= r_a_job;
            r_b_lo    <= (CURV_W + LO_W)'(i_cfg.curvature)
                         * (CURV_W + LO_W)'(r_a_sq[LO_W-1:0]);
            r_b_hi    <= (CURV_W + HI_W)'(i_cfg.curvature)
                         * (CURV_W + HI_W)'(r_a_sq[SQ_W-1:LO_W]);
            r_c_job   <= r_b_job;
            r_c_rnd   <= n_prod[PROD_W:2*ANGLE_FRAC_BITS];
            r_out_job <= r_c_job;
            r_out_fwd <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= o_q_pop;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_beam_angle    = r_out_job.angle;
    assign o_forward_angle = r_out_fwd;
    assign o_face          = r_out_job.face;
    assign o_pulse_left    = r_out_job.left;

    a_nadir_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_job.face == FACE_NADIR) |-> r_out_fwd == '0)
        else $error("tilt on nadir face");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out_fwd))
        else $error("waiting result lost");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_c_valid) && $stable(r_b_valid) && $stable(r_a_valid))
        else $error("pipeline moved while stalled");

endmodule

FILE: design/three_face_scan_angle_generator_top.sv
`timescale 1ns / 1ps

// channel   | handshake                      | payload
// ----------+--------------------------------+-------------------------------------------
// pulse in  | i_push / o_full                | i_restart
// result    | o_empty / i_pop                | o_beam_angle, o_forward_angle, o_face,
//           |                                | o_pulse_left
// config    | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one item per cycle while the result side keeps taking; an accepted item goes
// through the queue, then the square, split product, round and saturate stages.
// i_rst_n is synchronous: clears angle, face, queue and pipeline, loads default config.
// a result not taken freezes the tilt pipeline; the queue then fills and o_full rises.
module three_face_scan_angle_generator_top
    import tfsag_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic                   i_restart,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [ANGLE_W-1:0]     o_beam_angle,
    output logic [ANGLE_W-1:0]     o_forward_angle,
    output logic [1:0]             o_face,
    output logic                   o_pulse_left,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HALF_RANGE   = 3'd0,
        CFG_PULSE_STEP   = 3'd1,
        CFG_CURVATURE    = 3'd2,
        CFG_CENTRE_TILT  = 3'd3,
        CFG_NADIR_LIMIT  = 3'd4,
        CFG_TILTED_LIMIT = 3'd5,
        CFG_VERT_MIN     = 3'd6,
        CFG_VERT_MAX     = 3'd7
    } t_cfg_idx;

    t_cfg r_cfg;
    logic w_q_push;
    t_job w_push_job;
    logic w_q_full;
    logic w_q_pop;
    t_job w_pop_job;
    logic w_q_empty;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_half_range <= RANGE_W'(32768);
            r_cfg.pulse_step      <= RANGE_W'(66);
            r_cfg.curvature       <= CURV_W'(22876);
            r_cfg.centre_tilt     <= RANGE_W'(11438);
            r_cfg.nadir_limit     <= RANGE_W'(32768);
            r_cfg.tilted_limit    <= RANGE_W'(32768);
            r_cfg.vertical_min    <= ANGLE_W'(-32768);
            r_cfg.vertical_max    <= ANGLE_W'(32768);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_RANGE:   r_cfg.scan_half_range <= i_cfg_data[RANGE_W-1:0];
                CFG_PULSE_STEP:   r_cfg.pulse_step      <= i_cfg_data[RANGE_W-1:0];
                CFG_CURVATURE:    r_cfg.curvature       <= i_cfg_data[CURV_W-1:0];
                CFG_CENTRE_TILT:  r_cfg.centre_tilt     <= i_cfg_data[RANGE_W-1:0];
                CFG_NADIR_LIMIT:  r_cfg.nadir_limit     <= i_cfg_data[RANGE_W-1:0];
                CFG_TILTED_LIMIT: r_cfg.tilted_limit    <= i_cfg_data[RANGE_W-1:0];
                CFG_VERT_MIN:     r_cfg.vertical_min    <= i_cfg_data[ANGLE_W-1:0];
                CFG_VERT_MAX:     r_cfg.vertical_max    <= i_cfg_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tfsag_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_push    (i_push),
        .i_restart (i_restart),
        .i_full    (w_q_full),
        .o_push    (w_q_push),
        .o_job     (w_push_job)
    );

    tfsag_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_pop_job),
        .o_empty (w_q_empty)
    );

    tfsag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job           (w_pop_job),
        .i_q_empty       (w_q_empty),
        .o_q_pop         (w_q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_beam_angle    (o_beam_angle),
        .o_forward_angle (o_forward_angle),
        .o_face          (o_face),
        .o_pulse_left    (o_pulse_left)
    );

endmodule
